// ----- src/tad_pkg.sv -----
`timescale 1ns / 1ps
// tad_pkg: word types, widths and the depth divide helper for triangle_area_depth
package tad_pkg;

  localparam int CoordW = 16;
  localparam int SqSumW = 34;
  localparam int EdgeW = 17;
  localparam int SumW = 19;
  localparam int ProdW = 76;
  localparam int RootW = 39;
  localparam int AreaW = 36;
  localparam int ZSumW = 18;
  localparam int NumLanes = 3;

  typedef struct packed {
    logic signed [CoordW-1:0] ax;
    logic signed [CoordW-1:0] ay;
    logic signed [CoordW-1:0] az;
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by_coord;
    logic signed [CoordW-1:0] bz;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] cz;
  } in_word_t;

  typedef struct packed {
    logic [AreaW-1:0] area;
    logic signed [CoordW-1:0] depth;
  } out_word_t;

  // truncating divide by three of an 18-bit signed sum, via reciprocal
  function automatic logic signed [CoordW-1:0] div3(input logic signed [ZSumW-1:0] v);
    logic [ZSumW-1:0] mag;
    logic [ZSumW+18:0] prod;
    logic [ZSumW-1:0] q;
    mag = v[ZSumW-1] ? ZSumW'(-v) : v;
    prod = (ZSumW+19)'(mag) * (ZSumW+19)'(19'd174763);
    q = prod[ZSumW+18:19];
    if (v[ZSumW-1]) q = ZSumW'(-q);
    return q[CoordW-1:0];
  endfunction

endpackage

// ----- src/tad_sqrt_pipe.sv -----
`timescale 1ns / 1ps
// tad_sqrt_pipe: pipelined restoring square root, one result bit per stage
module tad_sqrt_pipe #(
  parameter int InW = 34,
  parameter int OutW = 17
) (
  input  logic              clk,
  input  logic              en,
  input  logic [InW-1:0]    din,
  output logic [OutW-1:0]   root
);

  localparam int RemW = OutW + 2;
  localparam int ValW = 2 * OutW;

  logic [ValW-1:0] val_r [OutW+1];
  logic [RemW-1:0] rem_r [OutW+1];
  logic [OutW-1:0] q_r   [OutW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      val_r[0] <= ValW'(din);
      rem_r[0] <= '0;
      q_r[0]   <= '0;
    end
  end

  for (genvar s = 0; s < OutW; s++) begin : g_stage
    logic [RemW-1:0] rem_sh;
    logic [RemW-1:0] trial;
    always_comb begin
      rem_sh = {rem_r[s][RemW-3:0], val_r[s][ValW-1:ValW-2]};
      trial  = {q_r[s], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        val_r[s+1] <= {val_r[s][ValW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_r[s+1] <= rem_sh - trial;
          q_r[s+1]   <= {q_r[s][OutW-2:0], 1'b1};
        end else begin
          rem_r[s+1] <= rem_sh;
          q_r[s+1]   <= {q_r[s][OutW-2:0], 1'b0};
        end
      end
    end
  end

  assign root = q_r[OutW];

endmodule

// ----- src/tad_edge_lane.sv -----
`timescale 1ns / 1ps
// tad_edge_lane: one edge length lane, squared differences then root
module tad_edge_lane (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [tad_pkg::CoordW-1:0]  x0, y0, z0, x1, y1, z1,
  output logic [tad_pkg::EdgeW-1:0]          len
);

  localparam int DW = tad_pkg::CoordW + 1;
  localparam int SqW = 2 * DW;

  logic signed [DW-1:0] dx_r, dy_r, dz_r;
  logic [SqW-1:0] sx_r, sy_r, sz_r;
  logic [tad_pkg::SqSumW-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= DW'(x0) - DW'(x1);
      dy_r <= DW'(y0) - DW'(y1);
      dz_r <= DW'(z0) - DW'(z1);
      sx_r <= SqW'(dx_r) * SqW'(dx_r);
      sy_r <= SqW'(dy_r) * SqW'(dy_r);
      sz_r <= SqW'(dz_r) * SqW'(dz_r);
      sum_r <= tad_pkg::SqSumW'(sx_r) + tad_pkg::SqSumW'(sy_r) + tad_pkg::SqSumW'(sz_r);
    end
  end

  tad_sqrt_pipe #(.InW(tad_pkg::SqSumW), .OutW(tad_pkg::EdgeW)) u_root (
    .clk(clk), .en(en), .din(sum_r), .root(len)
  );

endmodule

// ----- src/tad_heron.sv -----
`timescale 1ns / 1ps
// tad_heron: merges the lane lengths into the heron product and takes its root
module tad_heron (
  input  logic                        clk,
  input  logic                        en,
  input  logic [tad_pkg::EdgeW-1:0]   len_a, len_b, len_c,
  output logic [tad_pkg::AreaW-1:0]   area
);

  localparam int TW = tad_pkg::SumW;
  localparam int HW = 2 * TW;
  localparam int PW = tad_pkg::ProdW;

  logic [TW-1:0] t0_r, t1_r, t2_r, t3_r;
  logic [HW-1:0] left_r, right_r;
  // 38x38 product split into partial products over two stages
  logic [37:0] ll_r, lh_r, hl_r;
  logic [37:0] hh_r;
  logic [PW-1:0] prod_r;
  logic [tad_pkg::RootW-1:0] root;

  function automatic logic [TW-1:0] clamp(input logic signed [TW+1:0] v);
    return v[TW+1] ? '0 : v[TW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    logic signed [TW+1:0] sum;
    if (en) begin
      sum = (TW+2)'(len_a) + (TW+2)'(len_b) + (TW+2)'(len_c);
      t0_r <= sum[TW-1:0];
      t1_r <= clamp(sum - ((TW+2)'(len_a) << 1));
      t2_r <= clamp(sum - ((TW+2)'(len_b) << 1));
      t3_r <= clamp(sum - ((TW+2)'(len_c) << 1));
      left_r  <= HW'(t0_r) * HW'(t1_r);
      right_r <= HW'(t2_r) * HW'(t3_r);
      ll_r <= 38'(left_r[18:0]) * 38'(right_r[18:0]);
      lh_r <= 38'(left_r[18:0]) * 38'(right_r[37:19]);
      hl_r <= 38'(left_r[37:19]) * 38'(right_r[18:0]);
      hh_r <= 38'(left_r[37:19]) * 38'(right_r[37:19]);
      prod_r <= PW'(ll_r) + (PW'(lh_r) << 19) + (PW'(hl_r) << 19) + (PW'(hh_r) << 38);
    end
  end

  tad_sqrt_pipe #(.InW(PW), .OutW(tad_pkg::RootW)) u_root (
    .clk(clk), .en(en), .din(prod_r), .root(root)
  );

  assign area = root[tad_pkg::AreaW+1:2];

endmodule

// ----- src/triangle_area_depth.sv -----
`timescale 1ns / 1ps
// triangle area by heron's formula and mean depth, fully pipelined
// throughput: one word per cycle; the pipeline stalls as a whole only when its last
// stage and the output register both hold words and out_ready is low
// reset (rst_n, synchronous) clears valid bits only; no other state
module triangle_area_depth (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tad_pkg::in_word_t    in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tad_pkg::out_word_t   out_data
);

  localparam int Lat = 3 + tad_pkg::EdgeW + 1 + 4 + tad_pkg::RootW + 1;

  logic [Lat-1:0] vld_r;
  logic signed [tad_pkg::CoordW-1:0] dep_r [Lat];
  logic [tad_pkg::EdgeW-1:0] len [tad_pkg::NumLanes];
  logic [tad_pkg::AreaW-1:0] area;
  logic en;
  logic skid_vld_r;
  tad_pkg::out_word_t skid_r, pipe_word;

  // pipeline advances unless its last word cannot move into the output register
  assign en = !(vld_r[Lat-1] && skid_vld_r && !out_ready);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Lat-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dep_r[0] <= tad_pkg::div3(tad_pkg::ZSumW'(in_data.az) + tad_pkg::ZSumW'(in_data.bz)
                                + tad_pkg::ZSumW'(in_data.cz));
      for (int i = 1; i < Lat; i++) dep_r[i] <= dep_r[i-1];
    end
  end

  tad_edge_lane u_lane_a (.clk(clk), .en(en),
    .x0(in_data.ax), .y0(in_data.ay), .z0(in_data.az),
    .x1(in_data.bx), .y1(in_data.by_coord), .z1(in_data.bz), .len(len[0]));
  tad_edge_lane u_lane_b (.clk(clk), .en(en),
    .x0(in_data.bx), .y0(in_data.by_coord), .z0(in_data.bz),
    .x1(in_data.cx), .y1(in_data.cy), .z1(in_data.cz), .len(len[1]));
  tad_edge_lane u_lane_c (.clk(clk), .en(en),
    .x0(in_data.ax), .y0(in_data.ay), .z0(in_data.az),
    .x1(in_data.cx), .y1(in_data.cy), .z1(in_data.cz), .len(len[2]));

  tad_heron u_heron (.clk(clk), .en(en), .len_a(len[0]), .len_b(len[1]),
    .len_c(len[2]), .area(area));

  always_comb begin
    pipe_word.area  = area;
    pipe_word.depth = dep_r[Lat-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else if (!skid_vld_r || out_ready) begin
      skid_vld_r <= vld_r[Lat-1];
    end
  end

  always_ff @(posedge clk) begin
    if ((!skid_vld_r || out_ready) && vld_r[Lat-1]) begin
      skid_r <= pipe_word;
    end
  end

  assign out_valid = skid_vld_r;
  assign out_data  = skid_r;

endmodule

// ----- sim/tb_triangle_area_depth.sv -----
`timescale 1ns / 1ps
// testbench for triangle_area_depth: directed and random triangles checked against a predictor
module tb_triangle_area_depth;

  class area_depth_board;
    tad_pkg::out_word_t pending[$];
    int errors;
    int checked;

    function automatic logic [38:0] isqrt(input logic [77:0] v);
      logic [38:0] r;
      logic [38:0] c;
      r = '0;
      for (int b = 38; b >= 0; b--) begin
        c = r | (39'd1 << b);
        if (78'(c) * 78'(c) <= v) r = c;
      end
      return r;
    endfunction

    function automatic logic [16:0] edge_len(input logic signed [15:0] x0, y0, z0,
                                             input logic signed [15:0] x1, y1, z1);
      longint dx;
      longint dy;
      longint dz;
      logic [77:0] s;
      dx = longint'(x0) - longint'(x1);
      dy = longint'(y0) - longint'(y1);
      dz = longint'(z0) - longint'(z1);
      s = 78'(dx * dx) + 78'(dy * dy) + 78'(dz * dz);
      return 17'(isqrt(s));
    endfunction

    function automatic tad_pkg::out_word_t predict(input tad_pkg::in_word_t w);
      longint a;
      longint b;
      longint c;
      longint s;
      longint t[4];
      logic [77:0] prod;
      int zsum;
      tad_pkg::out_word_t r;
      a = edge_len(w.ax, w.ay, w.az, w.bx, w.by_coord, w.bz);
      b = edge_len(w.bx, w.by_coord, w.bz, w.cx, w.cy, w.cz);
      c = edge_len(w.ax, w.ay, w.az, w.cx, w.cy, w.cz);
      s = a + b + c;
      t[0] = s;
      t[1] = s - 2 * a;
      t[2] = s - 2 * b;
      t[3] = s - 2 * c;
      // negative heron term clamps to zero
      foreach (t[i]) if (t[i] < 0) t[i] = 0;
      prod = 78'(t[0] * t[1]) * 78'(t[2] * t[3]);
      r.area = tad_pkg::AreaW'(isqrt(prod) >> 2);
      zsum = int'(w.az) + int'(w.bz) + int'(w.cz);
      r.depth = 16'(zsum / 3);
      return r;
    endfunction

    function void note_input(input tad_pkg::in_word_t w);
      pending.insert(pending.size(), predict(w));
    endfunction

    function void check_result(input tad_pkg::out_word_t got);
      tad_pkg::out_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word area=%0d depth=%0d", $time, got.area, got.depth);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      checked++;
      if (got.area !== exp_w.area) begin
        $display("%0t: area expected %0d actual %0d", $time, exp_w.area, got.area);
        errors++;
      end
      if (got.depth !== exp_w.depth) begin
        $display("%0t: depth expected %0d actual %0d", $time, exp_w.depth, got.depth);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tad_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tad_pkg::out_word_t out_data;
  area_depth_board board;
  bit stim_done = 1'b0;
  int sent;

  triangle_area_depth dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.note_input(in_data);
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  task automatic send_word(input tad_pkg::in_word_t w);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic signed [15:0] rand_coord(input int spread);
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(spread);
      default: return 16'($urandom());
    endcase
  endfunction

  // triangles either full-range or small and nearly collinear
  function automatic tad_pkg::in_word_t rand_tri();
    tad_pkg::in_word_t w;
    int base;
    w = {$urandom(), $urandom(), $urandom(), $urandom(), 16'($urandom())};
    case ($urandom_range(0, 3))
      0: begin
        base = $urandom_range(0, 2000) - 1000;
        w.ax = 16'(base);
        w.bx = 16'(base + $urandom_range(0, 64));
        w.cx = 16'(base + $urandom_range(0, 64));
        w.ay = w.ax;
        w.by_coord = w.bx;
        w.cy = w.cx + 16'($urandom_range(0, 2));
        w.az = 16'($urandom_range(0, 40));
        w.bz = w.az;
        w.cz = -w.az;
      end
      1: begin
        w.ax = rand_coord(1);
        w.cz = rand_coord(-1);
        w.by_coord = rand_coord(0);
      end
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    board = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: coincident points, extremes, right triangle, collinear, depth signs
    send_word('0);
    send_word({9{16'sh7fff}});
    send_word({9{16'sh8000}});
    send_word({16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
               16'sh8000, 16'sh7fff, 16'sh7fff});
    send_word({16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff,
               16'sh7fff, 16'sh8000, 16'sh7fff});
    send_word({16'sd0, 16'sd0, 16'sd0, 16'sd768, 16'sd0, 16'sd0, 16'sd0, 16'sd1024, 16'sd0});
    send_word({16'sd0, 16'sd0, 16'sd1, 16'sd256, 16'sd256, 16'sd1, 16'sd512, 16'sd512,
               16'sd1});
    send_word({16'sd0, 16'sd0, -16'sd1, 16'sd1, 16'sd0, -16'sd1, 16'sd0, 16'sd1, 16'sd0});
    send_word({16'sd0, 16'sd0, -16'sd2, 16'sd1, 16'sd1, -16'sd2, 16'sd2, 16'sd1, -16'sd1});
    send_word({16'sd5, 16'sd5, 16'sd5, 16'sd6, 16'sd5, 16'sd5, 16'sd5, 16'sd6, 16'sd5});
    send_word({16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
               16'haaaa, 16'h5555});

    repeat (500) send_word(rand_tri());
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d triangles, checked %0d results (extremes, degenerate, random)",
             sent, board.checked);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("TEST FAILED");
    $finish;
  end
endmodule

// ----- sim.f -----
src/tad_pkg.sv
src/tad_sqrt_pipe.sv
src/tad_edge_lane.sv
src/tad_heron.sv
src/triangle_area_depth.sv
sim/tb_triangle_area_depth.sv
